@@ hdl/sss_pkg.sv @@
// Package for the state-space step block: operation codes, coefficient
// selectors, register indexes and fixed-point helpers.
// No dependencies.
`default_nettype none
package sss_pkg;
  localparam int WordW = 32;
  localparam int AccW = 72;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [AccW-1:0] acc_t;

  localparam logic [1:0] OP_COEF = 2'd0;
  localparam logic [1:0] OP_STATE = 2'd1;
  localparam logic [1:0] OP_DIST = 2'd2;
  localparam logic [1:0] OP_STEP = 2'd3;

  localparam logic [2:0] SEL_A = 3'd0;
  localparam logic [2:0] SEL_N = 3'd1;
  localparam logic [2:0] SEL_G = 3'd2;
  localparam logic [2:0] SEL_B = 3'd3;
  localparam logic [2:0] SEL_F = 3'd4;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_F = 3'd1;
  localparam logic [2:0] REG_B = 3'd2;
  localparam logic [2:0] REG_N = 3'd3;
  localparam logic [2:0] REG_G = 3'd4;

  // Control word that the sequencer drives into each cell.
  typedef struct packed {
    logic clear;   // load acc with the base operand
    logic mac;     // add the rounded product
    logic add;     // add the addend word
    logic commit;  // store saturated acc into x
  } cell_ctl_t;

  // Saturate a wide sum to the signed 32-bit range.
  function automatic word_t sat_word(input acc_t v);
    acc_t hi;
    acc_t lo;
    begin
      hi = acc_t'(32'sh7fffffff);
      lo = -acc_t'(64'sh80000000);
      if (v > hi) sat_word = 32'sh7fffffff;
      else if (v < lo) sat_word = 32'sh80000000;
      else sat_word = v[WordW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ hdl/sss_cell.sv @@
// One cell of the row: holds one state element and its accumulator.
// The multiplier operand arrives from the left neighbor and leaves to the right.
// Depends on sss_pkg.
`default_nettype none
module sss_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  sss_pkg::cell_ctl_t   ctl,
  input  sss_pkg::word_t       coef,     // this row's coefficient
  input  sss_pkg::word_t       addend,   // F or base word
  input  sss_pkg::word_t       opnd_in,  // operand from left neighbor
  output sss_pkg::word_t       opnd_out, // operand to right neighbor
  output sss_pkg::word_t       x,
  input  wire                  x_wr,     // direct write of the state element
  input  sss_pkg::word_t       x_wdata
);
  import sss_pkg::*;

  logic signed [63:0] prod;
  logic signed [64:0] rnd;
  acc_t term;
  acc_t acc;
  word_t opnd;
  word_t x_reg;

  // Rounded product, half LSB added then floor.
  assign prod = 64'(coef) * 64'(opnd_in);
  always_comb begin
    if (FRAC_BITS > 0) rnd = 65'(prod) + (65'sd1 <<< (FRAC_BITS - 1));
    else rnd = 65'(prod);
    term = acc_t'(rnd >>> FRAC_BITS);
  end

  // Accumulator and stored state element.
  always_ff @(posedge clk) begin
    opnd <= opnd_in;
    if (ctl.clear) acc <= acc_t'(addend);
    else if (ctl.mac) acc <= acc + term;
    else if (ctl.add) acc <= acc + acc_t'(addend);
    if (rst) x_reg <= '0;
    else if (ctl.commit) x_reg <= sat_word(acc);
    else if (x_wr) x_reg <= x_wdata;
  end

  assign opnd_out = opnd;
  assign x = x_reg;
endmodule
`default_nettype wire

@@ hdl/state_space_step.sv @@
// Top level of the state-space step block: coefficient store, sequencer,
// row of cells and output register. Depends on sss_pkg and sss_cell.
//
// Channel   Direction  Handshake     Payload
// in        input      valid/stall   operation .. use_disturbance
// out       output     valid/stall   state_index, state_value, last
// cfg       input      wr_en         index, data
//
// A write item is taken whenever the block is idle. Each product term of a step
// is a sweep in which operands shift one cell per cycle along the row; A, G, B
// and N take one sweep each, and the u*x_j products, the commit and the drain
// each have a state of their own. The input stays stalled from a step until the
// drain ends. Reset is synchronous; a stall on the output holds the drain.
`default_nettype none
module state_space_step #(
  parameter int DIM = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [1:0]           operation,
  input  wire [2:0]           matrix_select,
  input  wire [3:0]           row_index,
  input  wire [3:0]           col_index,
  input  sss_pkg::word_t      load_value,
  input  sss_pkg::word_t      control_value,
  input  wire                 use_control,
  input  wire                 use_disturbance,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [3:0]          state_index,
  output sss_pkg::word_t      state_value,
  output logic                last,
  input  wire                 cfg_wr_en,
  input  wire [2:0]           cfg_index,
  input  wire                 cfg_data
);
  import sss_pkg::*;

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int TW = $clog2(2 * DIM);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_UX    = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [TW-1:0] SWEEP_LAST = TW'(2 * DIM - 2);
  localparam logic [TW-1:0] UX_LAST = TW'(DIM - 1);

  // Coefficient store: per-row registers, each read at a column the
  // sequencer picks.
  word_t amat [DIM][DIM];
  word_t nmat [DIM][DIM];
  word_t gmat [DIM][DIM];
  word_t bvec [DIM];
  word_t fvec [DIM];
  word_t dvec [DIM];

  logic a_present, f_present, b_present, n_present, g_present;
  logic [2:0] state;
  logic [TW-1:0] cnt;
  logic [2:0] mode;       // which matrix feeds the row
  logic do_ctl;
  logic do_g;
  word_t u_reg;
  word_t ux [DIM];        // saturated u*x_j
  logic [IW-1:0] ocnt;
  logic ocnt_done;
  logic in_xfer;
  logic step_go;
  logic commit;
  logic row_ok, col_ok;
  logic [IW-1:0] ri, ci, col;
  logic [TW-1:0] vlen;
  word_t opnd [DIM+1];
  word_t xv [DIM];
  word_t feed;
  logic signed [63:0] uxp;
  logic signed [64:0] uxr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_present <= 1'b0; f_present <= 1'b0; b_present <= 1'b0;
      n_present <= 1'b0; g_present <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A: a_present <= cfg_data;
        REG_F: f_present <= cfg_data;
        REG_B: b_present <= cfg_data;
        REG_N: n_present <= cfg_data;
        REG_G: g_present <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign step_go = in_xfer && (operation == OP_STEP);
  assign commit = (state == S_ADD);

  assign row_ok = (32'(row_index) < DIM);
  assign col_ok = (32'(col_index) < DIM);
  assign ri = row_index[IW-1:0];
  assign ci = col_index[IW-1:0];

  // Coefficient writes.
  always_ff @(posedge clk) begin
    if (in_xfer && row_ok) begin
      if (operation == OP_COEF) begin
        case (matrix_select)
          SEL_A: if (col_ok) amat[ri][ci] <= load_value;
          SEL_N: if (col_ok) nmat[ri][ci] <= load_value;
          SEL_G: if (col_ok) gmat[ri][ci] <= load_value;
          SEL_B: bvec[ri] <= load_value;
          SEL_F: fvec[ri] <= load_value;
          default: ;
        endcase
      end
    end
  end

  // Disturbance vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIM; k++) dvec[k] <= '0;
    end else if (in_xfer && row_ok && operation == OP_DIST) begin
      dvec[ri] <= load_value;
    end
  end

  // Vector length of the current sweep: B carries the single operand u.
  assign vlen = (mode == SEL_B) ? TW'(1) : TW'(DIM);
  assign col = cnt[IW-1:0];

  // Row of cells. Cell i sees operand element (cnt - i) since operands
  // shift one cell per cycle.
  for (genvar i = 0; i < DIM; i++) begin : g_row
    logic [TW-1:0] jj;
    logic [IW-1:0] j;
    logic act;
    logic x_wr;
    word_t coef_i;
    word_t addend_i;
    cell_ctl_t cctl;
    assign jj = cnt - TW'(i);
    assign j = jj[IW-1:0];
    assign act = (state == S_SWEEP) && (cnt >= TW'(i)) && (jj < vlen);
    assign x_wr = in_xfer && (operation == OP_STATE) && row_ok && (ri == IW'(i));
    assign addend_i = !a_present ? xv[i] : (f_present ? fvec[i] : '0);
    assign cctl = {step_go, act, 1'b0, commit};
    always_comb begin
      case (mode)
        SEL_A: coef_i = amat[i][j];
        SEL_N: coef_i = nmat[i][j];
        SEL_G: coef_i = gmat[i][j];
        default: coef_i = bvec[i];
      endcase
    end
    sss_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst(rst),
      .ctl(cctl),
      .coef(coef_i), .addend(addend_i),
      .opnd_in(opnd[i]), .opnd_out(opnd[i+1]),
      .x(xv[i]),
      .x_wr(x_wr), .x_wdata(load_value)
    );
  end

  // Operand fed into the left end of the row.
  always_comb begin
    feed = '0;
    if (state == S_SWEEP && cnt < vlen) begin
      case (mode)
        SEL_A: feed = xv[col];
        SEL_N: feed = ux[col];
        SEL_G: feed = dvec[col];
        default: feed = u_reg;
      endcase
    end
  end
  assign opnd[0] = feed;

  // Control value of the step in progress.
  always_ff @(posedge clk) begin
    if (step_go) u_reg <= control_value;
  end

  // u*x_j for the bilinear term, one element per cycle.
  assign uxp = 64'(u_reg) * 64'(xv[col]);
  always_comb begin
    if (FRAC_BITS > 0) uxr = 65'(uxp) + (65'sd1 <<< (FRAC_BITS - 1));
    else uxr = 65'(uxp);
  end
  always_ff @(posedge clk) begin
    if (state == S_UX) ux[col] <= sat_word(acc_t'(uxr >>> FRAC_BITS));
  end

  assign ocnt_done = (ocnt == IW'(DIM - 1));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ocnt <= '0;
      mode <= SEL_A;
      do_ctl <= 1'b0;
      do_g <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (step_go) begin
          cnt <= '0;
          do_ctl <= !use_disturbance && use_control && b_present;
          do_g <= use_disturbance && g_present;
          if (a_present) begin
            mode <= SEL_A; state <= S_SWEEP;
          end else if (use_disturbance && g_present) begin
            mode <= SEL_G; state <= S_SWEEP;
          end else if (!use_disturbance && use_control && b_present) begin
            state <= S_UX;
          end else begin
            state <= S_ADD;
          end
        end
        S_SWEEP: begin
          if (cnt == SWEEP_LAST) begin
            cnt <= '0;
            if (mode == SEL_A && do_g) mode <= SEL_G;
            else if (mode == SEL_A && do_ctl) state <= S_UX;
            else if (mode == SEL_B && n_present) mode <= SEL_N;
            else state <= S_ADD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_UX: begin
          if (cnt == UX_LAST) begin
            cnt <= '0;
            mode <= SEL_B;
            state <= S_SWEEP;
          end else cnt <= cnt + 1'b1;
        end
        S_ADD: begin
          ocnt <= '0;
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          if (ocnt_done) state <= S_IDLE;
          else ocnt <= ocnt + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      state_index <= 4'(ocnt);
      state_value <= xv[ocnt];
      last <= ocnt_done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Assertions.
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(state_value)) else $error("output changed");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(state_index) < DIM)) else $error("index out of range");
endmodule
`default_nettype wire

@@ tb/state_space_step_tb.sv @@
// Self-checking testbench for the state-space step block: loads coefficients,
// state and disturbance, runs steps under several register settings and checks
// every emitted state element. Depends on sss_pkg and the state_space_step RTL.
`timescale 1ns / 1ps
`default_nettype none
module state_space_step_tb;
  import sss_pkg::*;

  localparam int DIM = 4;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 3 * DIM + 12;

  typedef struct {
    logic [3:0] idx;
    int val;
    bit last;
  } elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = OP_COEF;
  logic [2:0] matrix_select = SEL_A;
  logic [3:0] row_index = '0;
  logic [3:0] col_index = '0;
  word_t load_value = '0;
  word_t control_value = '0;
  logic use_control = 1'b0;
  logic use_disturbance = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] state_index;
  word_t state_value;
  logic last;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = REG_A;
  logic cfg_data = 1'b0;

  // Predictor state: its own copy of the coefficients, vectors and flags.
  int coef_a[DIM][DIM];
  int coef_n[DIM][DIM];
  int coef_g[DIM][DIM];
  int vec_b[DIM];
  int vec_f[DIM];
  int x_now[DIM];
  int dist_vec[DIM];
  bit fa, ff, fb, fn, fg;

  elem_t pending_states[$];
  int errors = 0;
  int results_seen = 0;
  int steps_sent = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int stall_run = 0;

  state_space_step #(.DIM(DIM), .FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .matrix_select(matrix_select),
    .row_index(row_index), .col_index(col_index),
    .load_value(load_value), .control_value(control_value),
    .use_control(use_control), .use_disturbance(use_disturbance),
    .out_valid(out_valid), .out_stall(out_stall),
    .state_index(state_index), .state_value(state_value), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Product of two fixed-point words, rounded half up to FRAC fraction bits.
  function automatic longint round_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Apply one accepted item to the predictor; steps queue their new state.
  task automatic predict_item(logic [1:0] op, logic [2:0] sel, logic [3:0] r,
                              logic [3:0] c, int val, int u, bit uc, bit ud);
    longint acc[DIM];
    longint ux[DIM];
    elem_t e;
    if (op == OP_COEF) begin
      if (r < DIM) begin
        if (sel == SEL_A && c < DIM) coef_a[r][c] = val;
        else if (sel == SEL_N && c < DIM) coef_n[r][c] = val;
        else if (sel == SEL_G && c < DIM) coef_g[r][c] = val;
        else if (sel == SEL_B) vec_b[r] = val;
        else if (sel == SEL_F) vec_f[r] = val;
      end
    end else if (op == OP_STATE) begin
      if (r < DIM) x_now[r] = val;
    end else if (op == OP_DIST) begin
      if (r < DIM) dist_vec[r] = val;
    end else begin
      for (int i = 0; i < DIM; i++) begin
        if (fa) begin
          acc[i] = 0;
          for (int j = 0; j < DIM; j++) acc[i] += round_mul(coef_a[i][j], x_now[j]);
          if (ff) acc[i] += vec_f[i];
        end else begin
          acc[i] = x_now[i];
        end
      end
      if (uc && !ud) begin
        if (fb) begin
          for (int j = 0; j < DIM; j++) ux[j] = clip32(round_mul(u, x_now[j]));
          for (int i = 0; i < DIM; i++) begin
            acc[i] += round_mul(vec_b[i], u);
            if (fn)
              for (int j = 0; j < DIM; j++) acc[i] += round_mul(coef_n[i][j], ux[j]);
          end
        end
      end else if (ud && fg) begin
        for (int i = 0; i < DIM; i++)
          for (int j = 0; j < DIM; j++) acc[i] += round_mul(coef_g[i][j], dist_vec[j]);
      end
      for (int i = 0; i < DIM; i++) begin
        x_now[i] = int'(clip32(acc[i]));
        e.idx = i[3:0];
        e.val = x_now[i];
        e.last = (i == DIM - 1);
        pending_states.push_back(e);
      end
      steps_sent++;
    end
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Values: a quarter full range, the rest near unity so states stay lively.
  function automatic int pick_value();
    if ($urandom_range(0, 3) == 0) return int'($urandom);
    return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
  endfunction

  // Drive one item and hold it until the block takes the transfer.
  task automatic send_item(logic [1:0] op, logic [2:0] sel, logic [3:0] r,
                           logic [3:0] c, int val, int u, bit uc, bit ud);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    matrix_select <= sel;
    row_index <= r;
    col_index <= c;
    load_value <= val;
    control_value <= u;
    use_control <= uc;
    use_disturbance <= ud;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(op, sel, r, c, val, u, uc, ud);
    items_sent++;
  endtask

  task automatic send_step(int u, bit uc, bit ud);
    send_item(OP_STEP, 3'($urandom), 4'($urandom), 4'($urandom), int'($urandom), u, uc, ud);
  endtask

  // Stop sending and wait until every queued state element has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_states.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all five present flags while the block is idle.
  task automatic set_flags(bit a, bit f, bit b, bit n, bit g);
    logic [2:0] regs[5];
    bit vals[5];
    regs = '{REG_A, REG_F, REG_B, REG_N, REG_G};
    vals = '{a, f, b, n, g};
    wait_drained();
    for (int k = 0; k < 5; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    {fa, ff, fb, fn, fg} = {a, f, b, n, g};
    @(posedge clk);
  endtask

  // Fill every coefficient, state and disturbance entry once.
  task automatic test_load_all();
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_item(OP_COEF, SEL_A, 4'(r), 4'(c), pick_value(), 0, 0, 0);
        send_item(OP_COEF, SEL_N, 4'(r), 4'(c), pick_value(), 0, 0, 0);
        send_item(OP_COEF, SEL_G, 4'(r), 4'(c), pick_value(), 0, 0, 0);
      end
      send_item(OP_COEF, SEL_B, 4'(r), 4'($urandom), pick_value(), 0, 0, 0);
      send_item(OP_COEF, SEL_F, 4'(r), 4'($urandom), pick_value(), 0, 0, 0);
      send_item(OP_STATE, 3'($urandom), 4'(r), 4'($urandom), pick_value(), 0, 0, 0);
      send_item(OP_DIST, 3'($urandom), 4'(r), 4'($urandom), pick_value(), 0, 0, 0);
    end
  endtask

  // Extremes, ignored writes and every step flavor.
  task automatic test_directed();
    set_flags(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_step(32'sh7fffffff, 1'b1, 1'b0);
    send_item(OP_STATE, SEL_A, 4'd0, 4'd0, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_STATE, SEL_A, 4'd1, 4'd0, 32'sh80000000, 0, 0, 0);
    send_item(OP_STATE, SEL_A, 4'd15, 4'd0, 32'sh12345678, 0, 0, 0);
    send_item(OP_DIST, SEL_A, 4'd15, 4'd0, 32'sh12345678, 0, 0, 0);
    send_item(OP_COEF, SEL_A, 4'd15, 4'd0, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_COEF, SEL_A, 4'd0, 4'd15, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_COEF, 3'd7, 4'd0, 4'd0, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_COEF, 3'd5, 4'd1, 4'd1, 32'sh80000000, 0, 0, 0);
    send_item(OP_COEF, SEL_B, 4'd15, 4'd0, 32'sh80000000, 0, 0, 0);
    send_step(0, 1'b0, 1'b0);
    set_flags(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(OP_COEF, SEL_A, 4'd0, 4'd0, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_COEF, SEL_B, 4'd3, 4'd0, 32'sh80000000, 0, 0, 0);
    send_step(32'sh7fffffff, 1'b1, 1'b0);
    send_step(32'sh80000000, 1'b1, 1'b0);
    send_step(32'sh80000000, 1'b1, 1'b1);
    send_step(32'sh00010000, 1'b0, 1'b1);
    set_flags(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_step(32'sh00020000, 1'b1, 1'b0);
    send_step(32'sh00020000, 1'b0, 1'b1);
  endtask

  // Random items: mostly steps under one flag setting, writes mixed in.
  task automatic test_random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_step(pick_value(), 1'($urandom), $urandom_range(0, 3) == 0);
      else if (r < 80)
        send_item(OP_COEF, 3'($urandom), 4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)),
                  pick_value(), int'($urandom), 1'($urandom), 1'($urandom));
      else
        send_item(2'($urandom_range(OP_STATE, OP_DIST)), 3'($urandom),
                  4'($urandom_range(0, 5)), 4'($urandom), pick_value(), int'($urandom),
                  1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      set_flags(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      calm = (p == 3);
      test_random_phase(40);
    end
    calm = 1'b0;
  endtask

  // Output stall: runs of random length, none while the run is calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < 15) begin
      out_stall <= 1'b1;
      stall_run <= ($urandom_range(0, 99) < 10) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expected state element.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d value %0d", $time, state_index,
                 state_value);
      end else begin
        elem_t e;
        e = pending_states.pop_front();
        if (state_index !== e.idx) begin
          errors++;
          $display("%0t: state_index expected %0d actual %0d", $time, e.idx, state_index);
        end
        if (state_value !== e.val) begin
          errors++;
          $display("%0t: state_value expected %0d actual %0d", $time, e.val, state_value);
        end
        if (last !== e.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, e.last, last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_states.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_all();
    test_directed();
    wait_drained();
    test_random();
    wait_drained();
    if (pending_states.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_states.size());
    end
    $display("Covered %0d items, %0d steps and %0d result transfers under random flag",
             items_sent, steps_sent, results_seen);
    $display("settings, input gaps and output stalls, plus directed extremes.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
